[design/sha256_stream_hasher_defines.svh]
// ----------------------------------------------------------------------------
// sha256 stream hasher assertion macros
// shared assertion forms for the hasher
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// implication checked on every clock, off during reset
`define SHA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SHA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha256 package
// shared types, constants and round functions
// ----------------------------------------------------------------------------
package sha_pkg;
	localparam int BytesPerItemDef = 8;
	localparam int QueueDepth = 2;

	typedef enum logic {
		MODE_ABSORB = 1'b0,
		MODE_FINAL  = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_PAD, ST_ROUND, ST_ADD, ST_EMIT
	} st_t;

	typedef struct packed {
		mode_t       mode;
		logic [63:0] data;
		logic [3:0]  count;
	} cmd_t;

	localparam logic [255:0] HashInit = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam logic [7:0] PadMarker = 8'h80;

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction
endpackage

[design/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256 stream hasher
// streaming sha-256 with a command queue in front of the compression engine
// ----------------------------------------------------------------------------
// An absorb transaction of n bytes (first byte in the top bits) is taken
// from the queue and loaded byte by byte; each full 64-byte block is then
// compressed in 64 rounds at one per cycle, followed by the hash update.
// A finalize places the marker as it is taken from the queue, then runs
// one or two compressions (pad, 64 rounds, update), then returns eight
// digest words, H0 first, last set on word 7, at one per cycle while the
// receiver is ready, and the hasher restarts. A two-entry queue lets input
// keep arriving while a block compresses.
module sha256_stream_hasher #(
	parameter int BytesPerItem = sha_pkg::BytesPerItemDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // message_bytes[63:0], byte_count[67:64], zeros
	input  logic        s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32], zeros
	output logic        m_tlast
);
	import sha_pkg::*;
	`include "sha256_stream_hasher_defines.svh"

	cmd_t        in_cmd, q_cmd;
	logic        q_valid, q_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;

	assign in_cmd.mode = mode_t'(s_tuser);
	assign in_cmd.data = s_tdata[63:0];
	assign in_cmd.count = s_tdata[67:64];

	sha_front #(.BytesPerItem(BytesPerItem)) u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	sha_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.out_valid(m_tvalid), .out_ready(m_tready),
		.digest_word, .word_index, .last(m_tlast)
	);

	assign m_tdata = {5'd0, word_index, digest_word};

	`SHA_ASSERT_IMP(a_last_idx, m_tvalid && m_tlast, word_index == 3'd7)
	`SHA_ASSERT_NEXT(a_idx_step, m_tvalid && m_tready && !m_tlast,
		m_tvalid && word_index == $past(word_index) + 3'd1)
	`SHA_ASSERT_IMP(a_no_take_emit, m_tvalid, !q_ready)
endmodule

[design/sha_front.sv]
// ----------------------------------------------------------------------------
// sha256 front end
// saturates counts, drops empty absorbs and queues commands
// ----------------------------------------------------------------------------
module sha_front #(
	parameter int BytesPerItem = sha_pkg::BytesPerItemDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sha_pkg::cmd_t in_cmd,
	output logic          q_valid,
	input  logic          q_ready,
	output sha_pkg::cmd_t q_cmd
);
	import sha_pkg::*;

	localparam logic [3:0] MaxCount = 4'(BytesPerItem);

	cmd_t       entry_q [QueueDepth];
	logic       wptr_q, rptr_q;
	logic [1:0] used_q;
	cmd_t       cls;
	logic       push, pop;

	always_comb begin
		cls = in_cmd;
		if (in_cmd.count > MaxCount) begin
			cls.count = MaxCount;
		end
	end

	assign in_ready = (used_q != 2'(QueueDepth));
	assign push = in_valid && in_ready &&
		!(in_cmd.mode == MODE_ABSORB && in_cmd.count == 4'd0);
	assign q_valid = (used_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_cmd = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			used_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			used_q <= used_q + 2'(push) - 2'(pop);
		end
	end
endmodule

[design/sha_back.sv]
// ----------------------------------------------------------------------------
// sha256 back end
// packs bytes, pads, runs one round per cycle and emits the digest
// ----------------------------------------------------------------------------
module sha_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  sha_pkg::cmd_t q_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   digest_word,
	output logic [2:0]    word_index,
	output logic          last
);
	import sha_pkg::*;

	st_t         state_q, state_d;
	logic [5:0]  fill_q;
	logic [60:0] total_q;
	logic [63:0] data_q;
	logic [3:0]  left_q;
	logic        final_q;
	logic        pad_len_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  t_q;
	logic [2:0]  oidx_q;
	logic        ovalid_q;

	logic [31:0] wt, s0, s1, t1, t2, e, a;
	logic [63:0] bits;
	logic        wr_byte;
	logic [7:0]  wr_val;
	assign bits = {total_q, 3'b000};
	assign wr_byte = (state_q == ST_LOAD) ||
		(state_q == ST_IDLE && q_valid && q_cmd.mode == MODE_FINAL);
	assign wr_val = (state_q == ST_LOAD) ? data_q[63:56] : PadMarker;

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wt = (t_q < 6'd16) ? w_q[0] : (s1 + w_q[9] + s0 + w_q[0]);
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
			((e & v_q[5]) ^ (~e & v_q[6])) + round_k(t_q) + wt;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
			((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (q_valid) state_d = (q_cmd.mode == MODE_FINAL) ? ST_PAD : ST_LOAD;
			ST_LOAD:  begin
				if (fill_q == 6'd63) state_d = ST_ROUND;
				else if (left_q == 4'd1) state_d = ST_IDLE;
			end
			ST_PAD:   state_d = ST_ROUND;
			ST_ROUND: if (t_q == 6'd63) state_d = ST_ADD;
			ST_ADD:   begin
				if (!final_q) state_d = (left_q != 4'd0) ? ST_LOAD : ST_IDLE;
				else if (pad_len_q) state_d = ST_PAD;
				else state_d = ST_EMIT;
			end
			ST_EMIT:  if (out_ready && oidx_q == 3'd7 && ovalid_q) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= 6'd0;
			total_q <= 61'd0;
			final_q <= 1'b0;
			pad_len_q <= 1'b0;
			left_q <= 4'd0;
			t_q <= 6'd0;
			oidx_q <= 3'd0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= HashInit[255 - 32*i -: 32];
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: if (q_valid) begin
					final_q <= (q_cmd.mode == MODE_FINAL);
					data_q <= q_cmd.data;
					left_q <= q_cmd.count;
					if (q_cmd.mode == MODE_ABSORB) begin
						total_q <= total_q + 61'(q_cmd.count);
					end else begin
						pad_len_q <= (fill_q >= 6'd56);
						fill_q <= fill_q + 6'd1;
					end
				end
				ST_LOAD: begin
					data_q <= {data_q[55:0], 8'h00};
					left_q <= left_q - 4'd1;
					fill_q <= fill_q + 6'd1;
				end
				ST_ROUND: begin
					t_q <= t_q + 6'd1;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					fill_q <= 6'd0;
					pad_len_q <= 1'b0;
					ovalid_q <= final_q && !pad_len_q;
				end
				ST_EMIT: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						ovalid_q <= 1'b0;
						fill_q <= 6'd0;
						total_q <= 61'd0;
						for (int i = 0; i < 8; i++) h_q[i] <= HashInit[255 - 32*i -: 32];
					end
				end
				default: ;
			endcase
			if (state_d == ST_ROUND && state_q != ST_ROUND) begin
				t_q <= 6'd0;
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
		end
	end

	// block bytes collect in the schedule window, big-endian within each word
	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wt;
		end else if (state_q == ST_PAD) begin
			for (int i = 0; i < 16; i++) begin
				for (int j = 0; j < 4; j++) begin
					if (6'(4*i + j) >= fill_q && !(pad_len_q && fill_q == 6'd0))
						w_q[i][31 - 8*j -: 8] <= 8'h00;
				end
			end
			if (!pad_len_q) begin
				w_q[14] <= bits[63:32];
				w_q[15] <= bits[31:0];
			end
		end else if (wr_byte) begin
			for (int j = 0; j < 4; j++) begin
				if (fill_q[1:0] == 2'(j)) w_q[fill_q[5:2]][31 - 8*j -: 8] <= wr_val;
			end
		end
	end

	assign out_valid = ovalid_q && state_q == ST_EMIT;
	assign digest_word = h_q[oidx_q];
	assign word_index = oidx_q;
	assign last = (oidx_q == 3'd7);
endmodule
